// ----- hdl/sua_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sua_pkg
// Shared types and constants for the SET/UA link establisher.
// ----------------------------------------------------------------------------
package sua_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_BYTE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_CONTROL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UA_CONTROL    = 3'd4;

    localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd3000;
    localparam logic [3:0]  RST_MAX_ATTEMPTS  = 4'd3;
    localparam logic [7:0]  RST_ADDRESS_BYTE  = 8'h03;
    localparam logic [7:0]  RST_SET_CONTROL   = 8'h03;
    localparam logic [7:0]  RST_UA_CONTROL    = 8'h07;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WAIT = 2'd1;
    localparam logic [1:0] ST_CONN = 2'd2;
    localparam logic [1:0] ST_FAIL = 2'd3;

    localparam logic [3:0] ATTEMPT_MAX = 4'hF;

    localparam int unsigned FRAME_LEN   = 5;
    localparam int unsigned BYTE_IDX_W  = $clog2(FRAME_LEN);
    localparam logic [BYTE_IDX_W-1:0] BYTE_FLAG_OPEN  = BYTE_IDX_W'(0);
    localparam logic [BYTE_IDX_W-1:0] BYTE_ADDRESS    = BYTE_IDX_W'(1);
    localparam logic [BYTE_IDX_W-1:0] BYTE_CONTROL    = BYTE_IDX_W'(2);
    localparam logic [BYTE_IDX_W-1:0] BYTE_BCC        = BYTE_IDX_W'(3);
    localparam logic [BYTE_IDX_W-1:0] BYTE_FLAG_CLOSE = BYTE_IDX_W'(FRAME_LEN - 1);

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [4:0] {
        PH_START = 5'b00001,
        PH_FLAG  = 5'b00010,
        PH_ADDR  = 5'b00100,
        PH_CTRL  = 5'b01000,
        PH_BCC   = 5'b10000
    } t_rx_phase;

    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_WAIT = 4'b0010,
        MODE_CONN = 4'b0100,
        MODE_FAIL = 4'b1000
    } t_link_mode;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [3:0]  max_attempts;
        logic [7:0]  address_byte;
        logic [7:0]  set_control;
        logic [7:0]  ua_control;
    } t_sua_cfg;

    typedef struct packed {
        logic       send;
        logic [1:0] status;
    } t_sua_cmd;

    function automatic logic [1:0] mode_to_status(input t_link_mode mode);
        logic [1:0] st;
        case (mode)
            MODE_IDLE: st = ST_IDLE;
            MODE_WAIT: st = ST_WAIT;
            MODE_CONN: st = ST_CONN;
            MODE_FAIL: st = ST_FAIL;
            default:   st = ST_IDLE;
        endcase
        return st;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/sua_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sua_front
// Request intake: link mode, UA deframer, timeout and retry counters.
// ----------------------------------------------------------------------------
module sua_front import sua_pkg::*; #(
    parameter int TIMER_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [7:0]  i_rx_byte,
    input  wire t_sua_cfg    i_cfg,
    input  wire logic        i_full,
    output logic             o_push,
    output t_sua_cmd         o_cmd
);

    localparam logic [TIMER_WIDTH-1:0] TMAX = '1;

    t_rx_phase              r_phase,   n_phase;
    t_link_mode             r_mode,    n_mode;
    logic [3:0]             r_attempt, n_attempt;
    logic [TIMER_WIDTH-1:0] r_tick,    n_tick;

    logic                   accept;
    logic                   send;
    logic [15:0]            lim16;
    logic [TIMER_WIDTH-1:0] limit;
    logic [TIMER_WIDTH-1:0] tick_inc;
    logic [3:0]             attempt_inc;
    logic [7:0]             bcc;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && !i_full;
    assign o_push     = accept;

    // timeout limit: zero acts as one, clamp to counter range
    assign lim16 = (i_cfg.timeout_ticks == 16'd0) ? 16'd1 : i_cfg.timeout_ticks;

    generate
        if (TIMER_WIDTH >= 16) begin : g_lim_wide
            assign limit = TIMER_WIDTH'(lim16);
        end else begin : g_lim_narrow
            assign limit = ((lim16 >> TIMER_WIDTH) != 16'd0) ? TMAX
                                                               : lim16[TIMER_WIDTH-1:0];
        end
    endgenerate

    assign tick_inc    = (r_tick == TMAX) ? r_tick : r_tick + 1'b1;
    assign attempt_inc = (r_attempt == ATTEMPT_MAX) ? r_attempt : r_attempt + 4'd1;
    assign bcc         = i_cfg.address_byte ^ i_cfg.ua_control;

    always_comb begin
        n_phase   = r_phase;
        n_mode    = r_mode;
        n_attempt = r_attempt;
        n_tick    = r_tick;
        send      = 1'b0;
        if (accept) begin
            if (i_req_type == REQ_START) begin
                n_phase   = PH_START;
                n_attempt = 4'd0;
                n_tick    = '0;
                n_mode    = MODE_WAIT;
                send      = 1'b1;
            end else if (r_mode == MODE_WAIT) begin
                case (i_req_type)
                    REQ_BYTE: begin
                        case (r_phase)
                            PH_START: begin
                                n_phase = (i_rx_byte == FLAG_BYTE) ? PH_FLAG : PH_START;
                            end
                            PH_FLAG: begin
                                if (i_rx_byte == i_cfg.address_byte) n_phase = PH_ADDR;
                                else if (i_rx_byte == FLAG_BYTE)     n_phase = PH_FLAG;
                                else                                 n_phase = PH_START;
                            end
                            PH_ADDR: begin
                                if (i_rx_byte == i_cfg.ua_control) n_phase = PH_CTRL;
                                else if (i_rx_byte == FLAG_BYTE)   n_phase = PH_FLAG;
                                else                               n_phase = PH_START;
                            end
                            PH_CTRL: begin
                                if (i_rx_byte == bcc)            n_phase = PH_BCC;
                                else if (i_rx_byte == FLAG_BYTE) n_phase = PH_FLAG;
                                else                             n_phase = PH_START;
                            end
                            PH_BCC: begin
                                if (i_rx_byte == FLAG_BYTE) begin
                                    n_mode = MODE_CONN;
                                    n_tick = '0;
                                end
                                n_phase = PH_START;
                            end
                            default: begin
                                n_phase = PH_START;
                            end
                        endcase
                    end
                    REQ_TICK: begin
                        n_tick = tick_inc;
                        if (tick_inc >= limit) begin
                            n_tick    = '0;
                            n_attempt = attempt_inc;
                            if (attempt_inc >= i_cfg.max_attempts) n_mode = MODE_FAIL;
                            send      = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_cmd.send   = send;
    assign o_cmd.status = mode_to_status(n_mode);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_START;
            r_mode    <= MODE_IDLE;
            r_attempt <= 4'd0;
            r_tick    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_mode    <= n_mode;
            r_attempt <= n_attempt;
            r_tick    <= n_tick;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/sua_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sua_queue
// Short command queue between the front end and the frame serialiser.
// ----------------------------------------------------------------------------
module sua_queue import sua_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_sua_cmd i_cmd,
    output logic          o_full,
    input  wire logic     i_pop,
    output t_sua_cmd      o_cmd,
    output logic          o_empty
);

    t_sua_cmd           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_count,  n_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) n_count = r_count + 1'b1;
        else if (!do_push && do_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/sua_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sua_back
// Result serialiser: SET frame bytes or a single status result per command.
// ----------------------------------------------------------------------------
module sua_back import sua_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_sua_cmd i_cmd,
    input  wire logic     i_empty,
    output logic          o_pop,
    input  wire t_sua_cfg i_cfg,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output logic          o_tx_valid,
    output logic [7:0]    o_tx_byte,
    output logic          o_last,
    output logic [1:0]    o_link_status
);

    logic [BYTE_IDX_W-1:0] r_idx, n_idx;
    logic                  r_out_valid;
    logic                  r_tx_valid;
    logic [7:0]            r_tx_byte;
    logic                  r_last;
    logic [1:0]            r_status;

    logic                  out_free;
    logic                  load;
    logic                  is_last;
    logic [7:0]            frame_byte;

    assign out_free = !r_out_valid || i_out_ready;
    assign load     = !i_empty && out_free;
    assign is_last  = !i_cmd.send || (r_idx == BYTE_FLAG_CLOSE);
    assign o_pop    = load && is_last;

    always_comb begin
        case (r_idx)
            BYTE_FLAG_OPEN:  frame_byte = FLAG_BYTE;
            BYTE_ADDRESS:    frame_byte = i_cfg.address_byte;
            BYTE_CONTROL:    frame_byte = i_cfg.set_control;
            BYTE_BCC:        frame_byte = i_cfg.address_byte ^ i_cfg.set_control;
            BYTE_FLAG_CLOSE: frame_byte = FLAG_BYTE;
            default:         frame_byte = FLAG_BYTE;
        endcase
    end

    always_comb begin
        n_idx = r_idx;
        if (load) begin
            n_idx = is_last ? BYTE_FLAG_OPEN : r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= BYTE_FLAG_OPEN;
            r_out_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (out_free) r_out_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tx_valid <= i_cmd.send;
            r_tx_byte  <= i_cmd.send ? frame_byte : 8'd0;
            r_last     <= is_last;
            r_status   <= i_cmd.status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_tx_valid    = r_tx_valid;
    assign o_tx_byte     = r_tx_byte;
    assign o_last        = r_last;
    assign o_link_status = r_status;

endmodule
`default_nettype wire

// ----- hdl/set_ua_link_establisher.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// set_ua_link_establisher
// Transmitter side of SET/UA link set-up with timeout and retries.
// ----------------------------------------------------------------------------
// A start request or a timer tick that times out yields five results, the
// SET frame bytes (flag, address, control, BCC, flag), one per cycle unless
// the output is stalled; every other request yields one status result. The
// front end updates the link state in the cycle a request is accepted and
// hands a command to a four-entry queue; the serialiser emits one result per
// cycle from it when the output is not stalled. link_status on every result
// is the status after that request. Configuration writes are taken at any
// time but are only meaningful while no request is in flight.
module set_ua_link_establisher import sua_pkg::*; #(
    parameter int TIMER_WIDTH = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [1:0]            i_req_type,
    input  wire logic [7:0]            i_rx_byte,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_tx_valid,
    output logic [7:0]                 o_tx_byte,
    output logic                       o_last,
    output logic [1:0]                 o_link_status,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_sua_cfg r_cfg;
    t_sua_cmd push_cmd;
    t_sua_cmd head_cmd;
    logic     push;
    logic     pop;
    logic     full;
    logic     empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ticks <= RST_TIMEOUT_TICKS;
            r_cfg.max_attempts  <= RST_MAX_ATTEMPTS;
            r_cfg.address_byte  <= RST_ADDRESS_BYTE;
            r_cfg.set_control   <= RST_SET_CONTROL;
            r_cfg.ua_control    <= RST_UA_CONTROL;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_TIMEOUT_TICKS: r_cfg.timeout_ticks <= i_cfg_wdata;
                CFG_MAX_ATTEMPTS:  r_cfg.max_attempts  <= i_cfg_wdata[3:0];
                CFG_ADDRESS_BYTE:  r_cfg.address_byte  <= i_cfg_wdata[7:0];
                CFG_SET_CONTROL:   r_cfg.set_control   <= i_cfg_wdata[7:0];
                CFG_UA_CONTROL:    r_cfg.ua_control    <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    sua_front #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_req_type (i_req_type),
        .i_rx_byte  (i_rx_byte),
        .i_cfg      (r_cfg),
        .i_full     (full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    sua_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (empty)
    );

    sua_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (head_cmd),
        .i_empty       (empty),
        .o_pop         (pop),
        .i_cfg         (r_cfg),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_tx_valid    (o_tx_valid),
        .o_tx_byte     (o_tx_byte),
        .o_last        (o_last),
        .o_link_status (o_link_status)
    );

    // status results carry no byte and close their request
    a_status_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_tx_valid |-> (o_tx_byte == 8'd0) && o_last)
        else $error("status result with byte or without last");

    // a frame continues in the next cycle with the same status
    a_frame_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_tx_valid && !o_last && i_out_ready |=>
            o_out_valid && o_tx_valid && (o_link_status == $past(o_link_status)))
        else $error("frame bytes broken up");

    // closing byte of a frame is a flag
    a_frame_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_tx_valid && o_last |-> (o_tx_byte == FLAG_BYTE))
        else $error("frame closing byte is not a flag");

endmodule
`default_nettype wire
